// ----- rtl/chev_pkg.sv -----
// Shared types, constants and register indexes for the complex Horner block.
// Used by the controller, the datapath, the top level and the port checker.
package chev_pkg;

   // Number format: two's complement, Q16.16 by default.
   localparam int DATA_WIDTH      = 32;
   localparam int FRAC_BITS       = 16;
   localparam int PROD_WIDTH      = 2 * DATA_WIDTH;
   localparam int CSR_INDEX_WIDTH = 3;

   // Four real products make one complex product.
   localparam int PRODUCT_COUNT   = 4;
   localparam int TERM_IDX_WIDTH  = $clog2(PRODUCT_COUNT);
   localparam int STEP_WIDTH      = $clog2(PRODUCT_COUNT + 1);

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   localparam data_type DATA_MAX  = data_type'({1'b0, {(DATA_WIDTH-1){1'b1}}});
   localparam data_type DATA_MIN  = data_type'({1'b1, {(DATA_WIDTH-1){1'b0}}});
   localparam data_type SCALE_ONE = data_type'(1) << FRAC_BITS;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POINT_RE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POINT_IM = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCALE_RE = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCALE_IM = 3'd4;

   // Operating modes.
   localparam logic MODE_EVALUATE = 1'b0;
   localparam logic MODE_DEFLATE  = 1'b1;

   // Product slots: accumulator part times operand part.
   localparam logic [TERM_IDX_WIDTH-1:0] TERM_RR = 2'd0;
   localparam logic [TERM_IDX_WIDTH-1:0] TERM_II = 2'd1;
   localparam logic [TERM_IDX_WIDTH-1:0] TERM_RI = 2'd2;
   localparam logic [TERM_IDX_WIDTH-1:0] TERM_IR = 2'd3;

   typedef struct packed {
      data_type coef_re;
      data_type coef_im;
      logic     final_coef;
   } chev_req_type;

   typedef struct packed {
      data_type value_re;
      data_type value_im;
      logic     end_of_run;
   } chev_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                      load_coef;
      logic                      load_acc_first;
      logic                      mul_issue;
      logic [TERM_IDX_WIDTH-1:0] mul_idx;
      logic                      sel_scale;
      logic                      term_capture;
      logic [TERM_IDX_WIDTH-1:0] term_idx;
      logic                      combine;
      logic                      update_acc;
      logic                      out_from_acc;
      logic                      out_from_cprod;
      logic                      out_last;
   } chev_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mode;
   } chev_status_type;

endpackage

// ----- rtl/chev_datapath.sv -----
// Datapath of the complex Horner block: configuration registers, accumulator,
// shared multiplier with saturation, complex combine and the result register.
// Depends on chev_pkg.
module chev_datapath
   import chev_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  data_type                   csr_wdata,
   input  chev_req_type               req_payload,
   input  chev_cmd_type               cmd,
   output chev_status_type            status,
   output chev_rsp_type               rsp_payload
);

   // Saturate a sum that has one bit of headroom.
   function automatic data_type sat_sum(input logic signed [DATA_WIDTH:0] s);
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
         return s[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
      end
      return data_type'(s[DATA_WIDTH-1:0]);
   endfunction

   logic                          mode_ff;
   data_type                      point_re_ff, point_im_ff;
   data_type                      scale_re_ff, scale_im_ff;
   data_type                      acc_re_ff, acc_im_ff;
   data_type                      coef_re_ff, coef_im_ff;
   logic signed [PROD_WIDTH-1:0]  prod_ff;
   logic signed [PROD_WIDTH-1:0]  prod_in;
   logic signed [PROD_WIDTH-1:0]  prod_shifted;
   logic [PROD_WIDTH-DATA_WIDTH:0] prod_top;
   data_type                      prod_sat;
   data_type                      term_ff [PRODUCT_COUNT];
   data_type                      cprod_re_ff, cprod_im_ff;
   data_type                      cprod_re_in, cprod_im_in;
   data_type                      acc_re_sum, acc_im_sum;
   data_type                      mul_a, mul_b, oper_re, oper_im;
   chev_rsp_type                  rsp_ff;

   // Configuration registers; a write to an unknown index is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_EVALUATE;
         point_re_ff <= '0;
         point_im_ff <= '0;
         scale_re_ff <= SCALE_ONE;
         scale_im_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODE:     mode_ff     <= csr_wdata[0];
            CSR_POINT_RE: point_re_ff <= csr_wdata;
            CSR_POINT_IM: point_im_ff <= csr_wdata;
            CSR_SCALE_RE: scale_re_ff <= csr_wdata;
            CSR_SCALE_IM: scale_im_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign status.mode = mode_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      oper_re = cmd.sel_scale ? scale_re_ff : point_re_ff;
      oper_im = cmd.sel_scale ? scale_im_ff : point_im_ff;
      mul_a   = (cmd.mul_idx == TERM_RR || cmd.mul_idx == TERM_RI) ? acc_re_ff : acc_im_ff;
      mul_b   = (cmd.mul_idx == TERM_RR || cmd.mul_idx == TERM_IR) ? oper_re : oper_im;
      prod_in = mul_a * mul_b;
   end

   // Full-precision product, registered before scaling.
   always_ff @(posedge clock) begin
      if (cmd.mul_issue) begin
         prod_ff <= prod_in;
      end
   end

   // Floor shift by the fraction width, then saturate to the data width.
   always_comb begin
      prod_shifted = prod_ff >>> FRAC_BITS;
      prod_top     = prod_shifted[PROD_WIDTH-1:DATA_WIDTH-1];
      if ((&prod_top) || !(|prod_top)) begin
         prod_sat = data_type'(prod_shifted[DATA_WIDTH-1:0]);
      end else begin
         prod_sat = prod_shifted[PROD_WIDTH-1] ? DATA_MIN : DATA_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.term_capture) begin
         term_ff[cmd.term_idx] <= prod_sat;
      end
   end

   // Complex combine: re = rr - ii, im = ri + ir.
   always_comb begin
      cprod_re_in = sat_sum({term_ff[TERM_RR][DATA_WIDTH-1], term_ff[TERM_RR]}
                          - {term_ff[TERM_II][DATA_WIDTH-1], term_ff[TERM_II]});
      cprod_im_in = sat_sum({term_ff[TERM_RI][DATA_WIDTH-1], term_ff[TERM_RI]}
                          + {term_ff[TERM_IR][DATA_WIDTH-1], term_ff[TERM_IR]});
      acc_re_sum  = sat_sum({cprod_re_ff[DATA_WIDTH-1], cprod_re_ff}
                          + {coef_re_ff[DATA_WIDTH-1], coef_re_ff});
      acc_im_sum  = sat_sum({cprod_im_ff[DATA_WIDTH-1], cprod_im_ff}
                          + {coef_im_ff[DATA_WIDTH-1], coef_im_ff});
   end

   always_ff @(posedge clock) begin
      if (cmd.combine) begin
         cprod_re_ff <= cprod_re_in;
         cprod_im_ff <= cprod_im_in;
      end
      if (cmd.load_coef) begin
         coef_re_ff <= req_payload.coef_re;
         coef_im_ff <= req_payload.coef_im;
      end
   end

   // Horner accumulator: loaded by a first coefficient, else updated.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (cmd.load_acc_first) begin
         acc_re_ff <= req_payload.coef_re;
         acc_im_ff <= req_payload.coef_im;
      end else if (cmd.update_acc) begin
         acc_re_ff <= acc_re_sum;
         acc_im_ff <= acc_im_sum;
      end
   end

   // Result register: the previous accumulator or the scaled value.
   always_ff @(posedge clock) begin
      if (cmd.out_from_acc) begin
         rsp_ff.value_re   <= acc_re_ff;
         rsp_ff.value_im   <= acc_im_ff;
         rsp_ff.end_of_run <= cmd.out_last;
      end else if (cmd.out_from_cprod) begin
         rsp_ff.value_re   <= cprod_re_ff;
         rsp_ff.value_im   <= cprod_im_ff;
         rsp_ff.end_of_run <= 1'b1;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/chev_controller.sv -----
// Controller of the complex Horner block: sequences the four products of each
// complex multiply, the combine, the accumulator update and the result transfer.
// Depends on chev_pkg.
module chev_controller
   import chev_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            final_coef,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  chev_status_type status,
   output chev_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_MUL     = 5'b00010,
      ST_COMBINE = 5'b00100,
      ST_UPDATE  = 5'b01000,
      ST_EMIT    = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in, step_prev;
   logic                  in_progress_ff, in_progress_in;
   logic                  last_ff, last_in;
   logic                  sel_scale_ff, sel_scale_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept, slot_free, rsp_load;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign step_prev = step_ff - STEP_WIDTH'(1);

   // Next state and datapath commands.
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      in_progress_in = in_progress_ff;
      last_in        = last_ff;
      sel_scale_in   = sel_scale_ff;
      rsp_load       = 1'b0;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.sel_scale  = sel_scale_ff;
      cmd.mul_idx    = step_ff[TERM_IDX_WIDTH-1:0];
      cmd.term_idx   = step_prev[TERM_IDX_WIDTH-1:0];
      cmd.out_last   = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_coef = accept;
            if (accept) begin
               in_progress_in = !final_coef;
               last_in        = final_coef;
               step_in        = '0;
               if (in_progress_ff) begin
                  // Horner step: multiply accumulator by the point.
                  sel_scale_in = 1'b0;
                  state_in     = ST_MUL;
               end else begin
                  // First coefficient seeds the accumulator.
                  cmd.load_acc_first = 1'b1;
                  if (status.mode == MODE_EVALUATE && final_coef) begin
                     sel_scale_in = 1'b1;
                     state_in     = ST_MUL;
                  end
               end
            end
         end

         ST_MUL: begin
            cmd.mul_issue    = (step_ff != STEP_WIDTH'(PRODUCT_COUNT));
            cmd.term_capture = (step_ff != '0);
            step_in          = step_ff + STEP_WIDTH'(1);
            if (step_ff == STEP_WIDTH'(PRODUCT_COUNT)) begin
               state_in = ST_COMBINE;
            end
         end

         ST_COMBINE: begin
            cmd.combine = 1'b1;
            state_in    = sel_scale_ff ? ST_EMIT : ST_UPDATE;
         end

         ST_UPDATE: begin
            // In deflate mode the old accumulator leaves in the same cycle.
            if (status.mode == MODE_EVALUATE || slot_free) begin
               cmd.update_acc   = 1'b1;
               cmd.out_from_acc = (status.mode == MODE_DEFLATE);
               rsp_load         = (status.mode == MODE_DEFLATE);
               if (status.mode == MODE_EVALUATE && last_ff) begin
                  sel_scale_in = 1'b1;
                  step_in      = '0;
                  state_in     = ST_MUL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_EMIT: begin
            if (slot_free) begin
               cmd.out_from_cprod = 1'b1;
               rsp_load           = 1'b1;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid: set on a load, cleared by a transfer.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         in_progress_ff <= 1'b0;
         last_ff        <= 1'b0;
         sel_scale_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         in_progress_ff <= in_progress_in;
         last_ff        <= last_in;
         sel_scale_ff   <= sel_scale_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/complex_horner_eval_deflate.sv -----
// Top level of the complex Horner evaluator and deflater.
// Instantiates chev_controller and chev_datapath; depends on chev_pkg.
// Usage:
//  - Coefficients arrive on the req_ channel highest degree first, one complex
//    Q16.16 value per transfer; final_coef marks the constant term.
//  - Results leave on the rsp_ channel. Evaluate mode gives one result per
//    polynomial, the value times the scale. Deflate mode gives one quotient
//    coefficient per coefficient after the first; end_of_run marks the last.
//  - The user must write registers on the csr_ channel, always ready, only while
//    no item is in flight; the block does not enforce it. Unknown indexes are ignored.
// Sequence:
//  - A first coefficient seeds the accumulator. Every later coefficient passes
//    through accept, the shared multiplier issuing four products, combine and
//    accumulator update. The last coefficient in evaluate mode adds the scale
//    multiply and the result transfer. The single shared multiplier serves
//    every product, and no coefficient is taken until the last is through.
// Reset: synchronous; the block returns to idle, awaiting a first
// coefficient, with scale 1.0 and point 0.
// Stall: a result waits in the output register; the next coefficient is still
// taken, and the block only waits when a new result needs that register.
module complex_horner_eval_deflate
   import chev_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  chev_req_type               req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output chev_rsp_type               rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  data_type                   csr_wdata
);

   chev_cmd_type    cmd;
   chev_status_type status;

   // Register writes are never stalled.
   assign csr_ready = 1'b1;

   chev_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .final_coef (req_payload.final_coef),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   chev_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- rtl/chev_checker.sv -----
// Port checker for the complex Horner block, bound to the top level.
// Depends on chev_pkg.
module chev_checker
   import chev_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input chev_req_type               req_payload,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input chev_rsp_type               rsp_payload,
   input logic                       csr_valid,
   input logic                       csr_ready,
   input logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input data_type                   csr_wdata
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("result payload changed while stalled");

   // Reset leaves the block idle with no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   // A new result is only produced while the input side is busy.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without work in progress");

endmodule

bind complex_horner_eval_deflate chev_checker u_chev_checker (.*);
